@@ hw/rtl/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

    // Bitmap geometry.
    localparam int NUM_FRAMES  = 4096;
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int LAST_FRAME  = NUM_FRAMES - 1;

    // The bitmap is stored as rows of WORD_W frame bits.
    localparam int WORD_W = 64;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = NUM_FRAMES / WORD_W;
    localparam int ROW_W  = $clog2(ROWS);

    // Request fields.
    localparam int ADDR_W      = 32;
    localparam int KIND_W      = 2;
    localparam int FNUM_W      = ADDR_W - FRAME_SHIFT + 1;
    localparam int FRAME_OUT_W = 12;
    localparam int IN_TDATA_W  = 2 * ADDR_W;
    localparam int OUT_TDATA_W = 16;

    // Request kinds.
    localparam logic [KIND_W-1:0] REQ_FREE  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_USED  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_ALLOC = 2'd2;

    // Operation of the shared word unit.
    typedef enum logic {
        WOP_MARK,
        WOP_ALLOC
    } t_wop;

    // Control group from the sequencer to the word unit.
    typedef struct packed {
        t_wop             op;
        logic             set_val;
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
    } t_wop_ctrl;

endpackage

@@ hw/rtl/bfa_bitmap_ram.sv @@
`timescale 1ns / 1ps

module bfa_bitmap_ram
    import bfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ROW_W-1:0]  i_rd_addr,
    output logic [WORD_W-1:0] o_rd_word,
    input  logic              i_wr_en,
    input  logic [ROW_W-1:0]  i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_word
);

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    // Row storage; no reset, rows are qualified by their valid bits.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_word;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A row that was never written reads as all used, since its valid bit is clear after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_data : '1;

endmodule

@@ hw/rtl/bfa_word_unit.sv @@
`timescale 1ns / 1ps

module bfa_word_unit
    import bfa_pkg::*;
(
    input  t_wop_ctrl         i_ctrl,
    input  logic [WORD_W-1:0] i_word,
    output logic [WORD_W-1:0] o_word,
    output logic              o_zero_found,
    output logic [BIT_W-1:0]  o_zero_idx
);

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [BIT_W-1:0]  hi_shift;
    logic [BIT_W-1:0]  idx;

    // Span of bits lo through hi inside one row.
    always_comb begin
        hi_shift = BIT_W'(WORD_W - 1) - i_ctrl.hi;
        lo_mask  = {WORD_W{1'b1}} << i_ctrl.lo;
        hi_mask  = {WORD_W{1'b1}} >> hi_shift;
        mask     = lo_mask & hi_mask;
    end

    // Lowest clear bit of the row.
    always_comb begin
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                idx = BIT_W'(i);
            end
        end
    end

    assign o_zero_found = ~&i_word;
    assign o_zero_idx   = idx;

    // Merged row for the write back.
    always_comb begin
        case (i_ctrl.op)
            WOP_MARK: begin
                o_word = i_ctrl.set_val ? (i_word | mask) : (i_word & ~mask);
            end
            WOP_ALLOC: begin
                o_word = i_word | (WORD_W'(1) << idx);
            end
            default: begin
                o_word = i_word;
            end
        endcase
    end

endmodule

@@ hw/rtl/bitmap_frame_allocator.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Payload, lowest bit first
// s_axis    in   tvalid tready tdata tuser  tdata: lo_addr[31:0], hi_addr[31:0]
//                                           tuser: req_type[1:0]
// m_axis    out  tvalid tready tdata tuser  tdata: alloc_frame[11:0], 4 zero bits
//                                           tuser: found
//
// A range request walks the rows that its span covers, and an allocate request scans rows
// until it finds a clear bit; an empty range or an unused code goes straight to the result.
// The bitmap is 64 rows of 64 bits behind one read and one write port, and the
// sequencer walks one row per cycle through the word unit.
// After reset every frame is used; per-row valid bits give that at once, with no clearing.
// A new request is taken while a result waits, but the next result waits for m_axis_tready.

module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // lo_addr, hi_addr
    input  logic [KIND_W-1:0]      s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // alloc_frame, zero pad
    output logic [0:0]             m_axis_tuser    // found
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RANGE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_set;
    logic [FRAME_W-1:0] r_first;
    logic [FRAME_W-1:0] r_last;
    logic [ROW_W-1:0]   r_row;
    logic               r_issue_done;
    logic               r_pipe_vld;
    logic [ROW_W-1:0]   r_pipe_row;
    logic [FRAME_W-1:0] r_res_frame;
    logic               r_res_found;
    logic               r_out_vld;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_found;

    logic                accept;
    logic [ADDR_W-1:0]   lo_addr;
    logic [ADDR_W-1:0]   hi_addr;
    logic [KIND_W-1:0]   req_type;
    logic [FNUM_W-1:0]   span_lo;
    logic [FNUM_W-1:0]   last_raw;
    logic [FNUM_W-1:0]   last_clamp;
    logic [ADDR_W:0]     end_up;
    logic                span_empty;
    logic                rd_en;
    logic                wr_en;
    logic [ROW_W-1:0]    last_row;
    logic [ROW_W-1:0]    first_row;
    logic                row_is_last;
    logic                out_free;
    t_wop_ctrl           wctrl;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   new_word;
    logic                zero_found;
    logic [BIT_W-1:0]    zero_idx;

    assign lo_addr  = s_axis_tdata[ADDR_W-1:0];
    assign hi_addr  = s_axis_tdata[IN_TDATA_W-1:ADDR_W];
    assign req_type = s_axis_tuser;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_vld || m_axis_tready;

    // Frame span of a range request, clipped to the bitmap.
    always_comb begin
        span_lo = {1'b0, lo_addr[ADDR_W-1:FRAME_SHIFT]};
        end_up  = {1'b0, hi_addr} + (ADDR_W + 1)'(FRAME_BYTES - 1);
        if (req_type == REQ_FREE) begin
            last_raw = {1'b0, hi_addr[ADDR_W-1:FRAME_SHIFT]};
        end else begin
            last_raw = end_up[ADDR_W:FRAME_SHIFT];
        end
        last_clamp = (last_raw > FNUM_W'(LAST_FRAME)) ? FNUM_W'(LAST_FRAME) : last_raw;
        span_empty = span_lo > last_clamp;
    end

    // Row walk bounds and the word unit's controls.
    always_comb begin
        first_row   = r_first[FRAME_W-1:BIT_W];
        last_row    = (r_state == S_SCAN) ? ROW_W'(ROWS - 1) : r_last[FRAME_W-1:BIT_W];
        row_is_last = r_pipe_row == last_row;
        wctrl.op      = (r_state == S_SCAN) ? WOP_ALLOC : WOP_MARK;
        wctrl.set_val = r_set;
        wctrl.lo      = (r_pipe_row == first_row) ? r_first[BIT_W-1:0] : '0;
        wctrl.hi      = (r_pipe_row == r_last[FRAME_W-1:BIT_W]) ? r_last[BIT_W-1:0] : '1;
    end

    assign rd_en = ((r_state == S_RANGE) || (r_state == S_SCAN)) && !r_issue_done;
    assign wr_en = r_pipe_vld && ((r_state == S_RANGE) || ((r_state == S_SCAN) && zero_found));

    bfa_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_row),
        .o_rd_word (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pipe_row),
        .i_wr_word (new_word)
    );

    bfa_word_unit u_word (
        .i_ctrl       (wctrl),
        .i_word       (rd_word),
        .o_word       (new_word),
        .o_zero_found (zero_found),
        .o_zero_idx   (zero_idx)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (req_type == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else if ((req_type inside {REQ_FREE, REQ_USED}) && !span_empty) begin
                        n_state = S_RANGE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RANGE: begin
                if (r_pipe_vld && row_is_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_pipe_vld && (zero_found || row_is_last)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, row pointers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue_done <= 1'b0;
            r_pipe_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pipe_vld <= rd_en;
            if (rd_en) begin
                r_pipe_row <= r_row;
                if (r_row == last_row) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end
            if (accept) begin
                r_set        <= req_type == REQ_USED;
                r_first      <= span_lo[FRAME_W-1:0];
                r_last       <= last_clamp[FRAME_W-1:0];
                r_row        <= (req_type == REQ_ALLOC) ? '0
                                : span_lo[FRAME_W-1:BIT_W];
                r_issue_done <= 1'b0;
                r_res_frame  <= '0;
                r_res_found  <= 1'b0;
            end
            if ((r_state == S_SCAN) && r_pipe_vld && zero_found) begin
                r_res_frame <= {r_pipe_row, zero_idx};
                r_res_found <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld   <= 1'b1;
                r_out_frame <= r_res_frame;
                r_out_found <= r_res_found;
            end else if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - FRAME_OUT_W){1'b0}},
                            r_out_frame[FRAME_OUT_W-1:0]};
    assign m_axis_tuser  = r_out_found;

`ifndef SYNTHESIS
    // The bitmap is only written while a request walks its rows.
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_RANGE || r_state == S_SCAN))
        else $error("bitmap written outside a row walk");

    // A range walk never writes past the last row of its span.
    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state == S_RANGE) |-> (r_pipe_row <= r_last[FRAME_W-1:BIT_W]))
        else $error("range write beyond the span");

    // No read is still in flight once the sequencer is idle.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pipe_vld)
        else $error("read in flight while idle");

    // A result without a found frame carries frame zero.
    a_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_found) |-> (r_out_frame == '0))
        else $error("nonzero frame on a result without a found frame");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bfa_pkg::*;

    // Request code that the block must ignore.
    localparam logic [KIND_W-1:0] REQ_NONE = 2'd3;

    localparam int RANDOM_REQS = 600;
    localparam int HOLD_AFTER  = 150;   // requests taken before the long output stall
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_TAIL  = 80;    // requests at the end sent with no idling
    localparam int SETTLE      = 80;    // above the longest request latency

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] hi_addr;
        bit                drain_first;   // wait for every grant before sending
    } t_frame_req;

    typedef struct {
        logic [FRAME_OUT_W-1:0] alloc_frame;
        logic                   found;
    } t_frame_grant;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // lo_addr, hi_addr
    logic [KIND_W-1:0]      s_axis_tuser;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // alloc_frame, zero pad
    logic [0:0]             m_axis_tuser;   // found

    t_frame_req   pending_reqs[$];
    t_frame_grant expected_grants[$];
    bit           used_map[NUM_FRAMES];

    t_frame_req   next_req;
    t_frame_grant oldest_grant;
    t_frame_grant new_grant;
    bit           req_taken;
    int           requests_taken;
    int           errors;
    int           src_gap;
    int           dst_gap;
    int           hold_left;
    bit           hold_done;

    bitmap_frame_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Sets or clears a span of frames; the part past the bitmap is dropped.
    function automatic void paint_frames(input longint unsigned lo_frame,
                                         input longint unsigned hi_frame,
                                         input bit val);
        longint unsigned f;
        if (hi_frame >= NUM_FRAMES) begin
            hi_frame = 64'(NUM_FRAMES - 1);
        end
        for (f = lo_frame; f <= hi_frame; f++) begin
            used_map[f] = val;
        end
    endfunction

    // Applies one request to the frame map and returns the grant it yields.
    function automatic t_frame_grant serve_request(input t_frame_req req);
        longint unsigned lo_frame;
        longint unsigned hi_byte;
        t_frame_grant    grant;
        grant.alloc_frame = '0;
        grant.found       = 1'b0;
        lo_frame = 64'(req.lo_addr);
        lo_frame = lo_frame / FRAME_BYTES;
        hi_byte  = 64'(req.hi_addr);
        case (req.kind)
            REQ_FREE: begin
                paint_frames(lo_frame, hi_byte / FRAME_BYTES, 1'b0);
            end
            REQ_USED: begin
                // The rounded-up end is computed wide, so it cannot wrap.
                paint_frames(lo_frame, (hi_byte + FRAME_BYTES - 1) / FRAME_BYTES, 1'b1);
            end
            REQ_ALLOC: begin
                for (int f = 0; f < NUM_FRAMES && !grant.found; f++) begin
                    if (!used_map[f]) begin
                        used_map[f]       = 1'b1;
                        grant.alloc_frame = FRAME_OUT_W'(f);
                        grant.found       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return grant;
    endfunction

    function automatic bit quiet_tail();
        return pending_reqs.size() < QUIET_TAIL;
    endfunction

    task automatic queue_req(input logic [KIND_W-1:0] kind,
                             input logic [ADDR_W-1:0] lo_addr,
                             input logic [ADDR_W-1:0] hi_addr,
                             input bit drain_first);
        t_frame_req req;
        req.kind        = kind;
        req.lo_addr     = lo_addr;
        req.hi_addr     = hi_addr;
        req.drain_first = drain_first;
        pending_reqs.push_back(req);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #400000;
        $display("FAIL bitmap_frame_allocator");
        $finish;
    end

    // Check each grant against the oldest prediction, then predict newly taken requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected grant frame=%0d found=%0b", $time,
                             m_axis_tdata[FRAME_OUT_W-1:0], m_axis_tuser[0]);
                    errors++;
                end else begin
                    oldest_grant = expected_grants.pop_front();
                    if (m_axis_tdata[FRAME_OUT_W-1:0] !== oldest_grant.alloc_frame) begin
                        $display("%0t: alloc_frame expected %0d actual %0d", $time,
                                 oldest_grant.alloc_frame, m_axis_tdata[FRAME_OUT_W-1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:FRAME_OUT_W] !== '0) begin
                        $display("%0t: tdata pad expected 0 actual %h", $time,
                                 m_axis_tdata[OUT_TDATA_W-1:FRAME_OUT_W]);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== oldest_grant.found) begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 oldest_grant.found, m_axis_tuser[0]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                next_req.kind    = s_axis_tuser;
                next_req.lo_addr = s_axis_tdata[ADDR_W-1:0];
                next_req.hi_addr = s_axis_tdata[2*ADDR_W-1:ADDR_W];
                new_grant = serve_request(next_req);
                expected_grants.push_back(new_grant);
                requests_taken <= requests_taken + 1;
            end
            req_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Request driver: holds a request until taken, idles in short random bursts.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs[0].drain_first && expected_grants.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
                src_gap       <= $urandom_range(0, 2);
                s_axis_tvalid <= 1'b0;
            end else begin
                next_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_req.hi_addr, next_req.lo_addr};
                s_axis_tuser  <= next_req.kind;
            end
        end
    end

    // Grant receiver: one long stall once, otherwise short random stalls.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (dst_gap > 0) begin
                dst_gap       <= dst_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(0, 5) == 0) begin
                dst_gap       <= $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        int mode;
        int base;
        int span;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] hi_addr;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = REQ_FREE;
        m_axis_tready  = 1'b0;
        req_taken      = 1'b0;
        requests_taken = 0;
        errors         = 0;
        src_gap        = 0;
        dst_gap        = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        foreach (used_map[f]) begin
            used_map[f] = 1'b1;
        end

        // Directed part: empty map, ignored code, clipped and empty ranges, full sweeps.
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_NONE,  32'h0000_0000, 32'h00FF_FFFF, 1'b0);
        queue_req(REQ_FREE,  32'h0000_0000, 32'h0000_FFFF, 1'b0);
        queue_req(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_USED,  32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_FREE,  32'h0000_5000, 32'h0000_1000, 1'b0);
        queue_req(REQ_FREE,  32'h00FF_F000, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_FREE,  32'h0100_0000, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_FREE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_USED,  32'h0000_0001, 32'h0000_1001, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_USED,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_FREE,  32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_FREE,  32'h00FF_FFFF, 32'h00FF_FFFF, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_FREE,  32'h0080_0000, 32'h0080_0FFF, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_req(REQ_USED,  32'h00FF_E001, 32'h00FF_F001, 1'b0);

        // Random part: mostly in-map ranges and allocations, some wild addresses.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                kind = REQ_FREE;
            end else if (pick < 45) begin
                kind = REQ_USED;
            end else if (pick < 93) begin
                kind = REQ_ALLOC;
            end else begin
                kind = REQ_NONE;
            end
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                lo_addr = $urandom;
                hi_addr = $urandom;
            end else if (mode == 1) begin
                base    = $urandom_range(1, NUM_FRAMES - 1);
                lo_addr = ADDR_W'(base * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
                hi_addr = ADDR_W'($urandom_range(0, base * FRAME_BYTES - 1));
            end else begin
                base = $urandom_range(0, NUM_FRAMES - 1);
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_FRAMES)
                                                   : $urandom_range(0, 40);
                lo_addr = ADDR_W'(base * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
                hi_addr = ADDR_W'((base + span) * FRAME_BYTES
                                  + $urandom_range(0, FRAME_BYTES - 1));
            end
            queue_req(kind, lo_addr, hi_addr, n == 200 || n == 400);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and every grant has come back.
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS bitmap_frame_allocator");
        end else begin
            $display("FAIL bitmap_frame_allocator");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_bitmap_ram.sv
hw/rtl/bfa_word_unit.sv
hw/rtl/bitmap_frame_allocator.sv
tb/tb.sv
